FILE: src/rqr_pkg.sv
// Shared types, constants and helpers for the ring queue with removal.
// Used by the controller, the datapath, the top level and the checker.
package rqr_pkg;

  localparam int DEPTH   = 16;
  localparam int ID_BITS = 8;
  localparam int PTR_W   = $clog2(DEPTH);
  localparam int CNT_W   = PTR_W + 1;

  typedef logic [ID_BITS-1:0] id_t;
  typedef logic [PTR_W-1:0]   ptr_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_POP    = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_NOP    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_INS_FULL  = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    latch_in;   // capture the request and clear the result
    logic    k_clear;
    logic    k_inc;
    logic    rd_k1;      // read slot at offset k+1 instead of k
    logic    wr_tail;    // write the request id at offset entry_count
    logic    wr_k;       // write the read data at offset k
    logic    head_adv;
    logic    count_inc;
    logic    count_dec;
    logic    take_pop;   // popped id takes the read data
    logic    set_status;
    status_t status;
    logic    load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    action_t action;
    logic    full;
    logic    empty;
    logic    match;
    logic    k_zero;
    logic    k_last;     // k+1 reaches entry_count
    logic    out_free;
  } sts_t;

  // Physical slot of the entry at offset off from head, wrapping at size.
  // Both head and off stay below size, so one subtraction is enough.
  function automatic ptr_t slot_index(ptr_t head, cnt_t off, cnt_t size);
    logic [CNT_W:0] sum;
    sum = {2'b00, head} + {1'b0, off};
    if (sum >= {1'b0, size}) begin
      sum = sum - {1'b0, size};
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

FILE: src/rqr_ctrl.sv
// Controller state machine of the ring queue: sequences insert, pop and
// the search-and-shift of a remove. Depends on rqr_pkg.
module rqr_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  rqr_pkg::sts_t sts,
  output rqr_pkg::cmd_t cmd
);
  import rqr_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_DISPATCH = 9'b000000010,
    S_POP_RD   = 9'b000000100,
    S_POP_TAKE = 9'b000001000,
    S_SRCH_RD  = 9'b000010000,
    S_SRCH_CMP = 9'b000100000,
    S_SHIFT_RD = 9'b001000000,
    S_SHIFT_WR = 9'b010000000,
    S_FINISH   = 9'b100000000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.status = ST_OK;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_next   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd.k_clear = 1'b1;
        case (sts.action)
          ACT_INSERT: begin
            if (sts.full) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_INS_FULL;
            end else begin
              cmd.wr_tail   = 1'b1;
              cmd.count_inc = 1'b1;
            end
            state_next = S_FINISH;
          end
          ACT_POP: begin
            if (sts.empty) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_POP_EMPTY;
              state_next     = S_FINISH;
            end else begin
              state_next = S_POP_RD;
            end
          end
          ACT_REMOVE: begin
            if (sts.empty) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_NOT_FOUND;
              state_next     = S_FINISH;
            end else begin
              state_next = S_SRCH_RD;
            end
          end
          default: begin
            state_next = S_FINISH;
          end
        endcase
      end
      S_POP_RD: begin
        state_next = S_POP_TAKE;
      end
      S_POP_TAKE: begin
        cmd.take_pop  = 1'b1;
        cmd.head_adv  = 1'b1;
        cmd.count_dec = 1'b1;
        state_next    = S_FINISH;
      end
      S_SRCH_RD: begin
        state_next = S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        if (sts.match) begin
          if (sts.k_zero) begin
            // Taking out the head entry only moves the head and lowers the count.
            cmd.head_adv  = 1'b1;
            cmd.count_dec = 1'b1;
            state_next    = S_FINISH;
          end else begin
            state_next = S_SHIFT_RD;
          end
        end else if (sts.k_last) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_NOT_FOUND;
          state_next     = S_FINISH;
        end else begin
          cmd.k_inc  = 1'b1;
          state_next = S_SRCH_RD;
        end
      end
      S_SHIFT_RD: begin
        if (sts.k_last) begin
          cmd.count_dec = 1'b1;
          state_next    = S_FINISH;
        end else begin
          cmd.rd_k1  = 1'b1;
          state_next = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd.wr_k   = 1'b1;
        cmd.k_inc  = 1'b1;
        state_next = S_SHIFT_RD;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: src/rqr_datapath.sv
// Datapath of the ring queue: slot memory, head and count registers, the
// search offset, the size register and the output register. Depends on rqr_pkg.
module rqr_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  rqr_pkg::cmd_t         cmd,
  output rqr_pkg::sts_t         sts,
  input  logic [1:0]            in_action,
  input  rqr_pkg::id_t          in_id,
  input  logic                  cfg_we,
  input  logic [4:0]            cfg_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output rqr_pkg::id_t          out_popped,
  output logic [1:0]            out_status,
  output rqr_pkg::cnt_t         out_count
);
  import rqr_pkg::*;

  id_t     slots [DEPTH];
  id_t     rdata;
  ptr_t    head;
  cnt_t    entry_count;
  ptr_t    k;
  logic [4:0] queue_size;
  action_t action;
  id_t     req_id;
  id_t     popped;
  status_t status;

  cnt_t    size;
  cnt_t    k_off;
  cnt_t    k1_off;
  ptr_t    rd_addr;
  ptr_t    wr_addr;
  cnt_t    head_inc;

  // Zero or anything above DEPTH behaves as the full ring.
  assign size = (queue_size == '0 || queue_size > 5'(DEPTH))
                ? CNT_W'(DEPTH) : CNT_W'(queue_size);

  assign k_off    = {1'b0, k};
  assign k1_off   = k_off + 1'b1;
  assign rd_addr  = slot_index(head, cmd.rd_k1 ? k1_off : k_off, size);
  assign wr_addr  = slot_index(head, cmd.wr_tail ? entry_count : k_off, size);
  assign head_inc = {1'b0, head} + 1'b1;

  always_ff @(posedge clk) begin
    rdata <= slots[rd_addr];
    if (cmd.wr_tail) begin
      slots[wr_addr] <= req_id;
    end else if (cmd.wr_k) begin
      slots[wr_addr] <= rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      queue_size  <= 5'(DEPTH);
      head        <= '0;
      entry_count <= '0;
    end else if (cfg_we) begin
      queue_size  <= cfg_data;
      head        <= '0;
      entry_count <= '0;
    end else begin
      if (cmd.head_adv) begin
        head <= (head_inc == size) ? '0 : head_inc[PTR_W-1:0];
      end
      if (cmd.count_inc) begin
        entry_count <= entry_count + 1'b1;
      end else if (cmd.count_dec) begin
        entry_count <= entry_count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      action <= action_t'(in_action);
      req_id <= in_id;
      popped <= '0;
      status <= ST_OK;
    end else begin
      if (cmd.take_pop) begin
        popped <= rdata;
      end
      if (cmd.set_status) begin
        status <= cmd.status;
      end
    end
    if (cmd.k_clear) begin
      k <= '0;
    end else if (cmd.k_inc) begin
      k <= k + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_popped <= popped;
      out_status <= status;
      out_count  <= entry_count;
    end
  end

  assign sts.action   = action;
  assign sts.full     = (entry_count >= size);
  assign sts.empty    = (entry_count == '0);
  assign sts.match    = (rdata == req_id);
  assign sts.k_zero   = (k == '0);
  assign sts.k_last   = (k1_off >= entry_count);
  assign sts.out_free = !out_valid || out_ready;

endmodule

FILE: src/ring_queue_with_removal_core.sv
// Top level of the ring queue with removal: stream ports around the
// controller (rqr_ctrl) and the datapath (rqr_datapath). Depends on rqr_pkg.
//
// Channel   Direction  Moves
// s_axis    in         request: action on tuser, process id on tdata
// m_axis    out        result: popped id and count on tdata, status on tuser
// cfg       in         write of queue_size, which also empties the queue
//
// One request at a time, from acceptance to the result: insert, no-op, pop on
// empty and remove on empty go through dispatch and finish; a pop adds a read
// and a take step; a remove searches from the head with a read and a compare
// step per slot, and a remove at offset k > 0 then shifts each later slot toward
// the head with a read and a write step, since the slot memory has a single read port.
// A new request is taken while the previous result waits in the output
// register; a stalled output holds the next result in the finish step.
// Reset is synchronous; it clears head and count, sets queue_size to DEPTH,
// and leaves the slot memory as it is.
module ring_queue_with_removal_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] process_id
  input  logic [1:0]  s_axis_tuser,   // [1:0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] popped_id, [12:8] item_count
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data
);
  import rqr_pkg::*;

  cmd_t cmd;
  sts_t sts;
  id_t  out_popped;
  cnt_t out_count;

  assign cfg_ready = 1'b1;

  rqr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rqr_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_action  (s_axis_tuser),
    .in_id      (s_axis_tdata),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_popped (out_popped),
    .out_status (m_axis_tuser),
    .out_count  (out_count)
  );

  assign m_axis_tdata = {3'b000, out_count, out_popped};

endmodule

FILE: src/rqr_checker.sv
// Port-level checks for the ring queue with removal, bound to the top level.
// Depends on rqr_pkg.
module rqr_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);
  import rqr_pkg::*;

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // Requests are handled one at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while another is in progress");

  // A pop on an empty queue reports an empty queue.
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == ST_POP_EMPTY |-> m_axis_tdata[12:8] == 5'd0)
    else $error("pop on empty with nonzero count");

  // An insert refused for lack of room cannot see an empty queue, and only
  // a successful request carries a popped identifier.
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == ST_INS_FULL |-> m_axis_tdata[12:8] != 5'd0)
    else $error("insert on full with zero count");

  a_popped_ok: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[7:0] != 8'd0 |-> m_axis_tuser == ST_OK)
    else $error("popped id with failing status");

endmodule

bind ring_queue_with_removal_core rqr_checker u_rqr_checker (.*);

FILE: dv/tb_ring_queue_with_removal_core.sv
// Self-checking testbench for ring_queue_with_removal_core: random and directed requests
// against a queue predictor, with bursty input and a stalling output. Depends on rqr_pkg.
module tb_ring_queue_with_removal_core;
  import rqr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int PHASE_ITEMS = 180;

  typedef struct packed {
    id_t     popped;
    status_t status;
    cnt_t    count;
  } result_t;

  // Tracks the queue contents and the results owed for accepted requests.
  class run_queue_tracker;
    id_t        ring[DEPTH];
    int         head_pos;
    int         held;
    logic [4:0] size_reg = 5'(DEPTH);
    result_t    pending_results[$];
    int         errors;

    function void write_size(logic [4:0] v);
      size_reg = v;
      head_pos = 0;
      held = 0;
    endfunction

    function int ring_len();
      if (size_reg == 0 || size_reg > DEPTH) return DEPTH;
      return int'(size_reg);
    endfunction

    function id_t entry_at(int k);
      return ring[(head_pos + k) % ring_len()];
    endfunction

    function void note_request(action_t act, id_t pid);
      result_t r;
      int len;
      int k;
      bit found;
      len = ring_len();
      r.popped = '0;
      r.status = ST_OK;
      head_pos = head_pos % len;
      if (held > len) held = len;
      case (act)
        ACT_INSERT: begin
          if (held >= len) begin
            r.status = ST_INS_FULL;
          end else begin
            ring[(head_pos + held) % len] = pid;
            held++;
          end
        end
        ACT_POP: begin
          if (held == 0) begin
            r.status = ST_POP_EMPTY;
          end else begin
            r.popped = ring[head_pos];
            head_pos = (head_pos + 1) % len;
            held--;
          end
        end
        ACT_REMOVE: begin
          found = 0;
          k = 0;
          while (k < held && !found) begin
            if (ring[(head_pos + k) % len] == pid) found = 1;
            else k++;
          end
          if (!found) begin
            r.status = ST_NOT_FOUND;
          end else begin
            // The head just moves on; anything else closes the gap toward the head.
            if (k == 0) begin
              head_pos = (head_pos + 1) % len;
            end else begin
              for (int m = k; m + 1 < held; m++)
                ring[(head_pos + m) % len] = ring[(head_pos + m + 1) % len];
            end
            held--;
          end
        end
        default: ;
      endcase
      r.count = cnt_t'(held);
      pending_results.push_back(r);
    endfunction

    function void check_result(logic [15:0] data, logic [1:0] user);
      result_t r;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, tdata %h tuser %0d", $time, data, user);
        errors++;
        return;
      end
      r = pending_results.pop_front();
      if (data[7:0] !== r.popped) begin
        $display("%0t: popped_id expected %0d actual %0d", $time, r.popped, data[7:0]);
        errors++;
      end
      if (data[12:8] !== r.count) begin
        $display("%0t: item_count expected %0d actual %0d", $time, r.count, data[12:8]);
        errors++;
      end
      if (data[15:13] !== 3'b000) begin
        $display("%0t: tdata pad expected 0 actual %0d", $time, data[15:13]);
        errors++;
      end
      if (user !== r.status) begin
        $display("%0t: status expected %0d actual %0d", $time, r.status, user);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [4:0]  cfg_data;

  int               hold_asks = 0;
  int unsigned      cycle_count = 0;
  run_queue_tracker tracker = new;

  ring_queue_with_removal_core uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_ring_queue_with_removal_core NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) tracker.check_result(m_axis_tdata, m_axis_tuser);
  end

  // Output stalls follow a pattern that changes now and then; a long hold-off is taken on
  // request so that the block backs up into its input.
  initial begin : result_stall
    int mode;
    int left;
    int hold_left;
    int holds_seen;
    mode = 0;
    left = 0;
    hold_left = 0;
    holds_seen = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_asks != holds_seen) begin
        holds_seen = hold_asks;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready = 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(20, 200);
        end
        left--;
        case (mode)
          0: m_axis_tready = 1'b1;
          1: m_axis_tready = 1'($urandom_range(0, 1));
          2: m_axis_tready = ($urandom_range(0, 5) == 0);
          default: m_axis_tready = (left % 3 == 0);
        endcase
      end
    end
  end

  task automatic push_request(action_t act, id_t pid);
    @(negedge clk);
    s_axis_tvalid = 1'b1;
    s_axis_tuser = act;
    s_axis_tdata = pid;
    do @(posedge clk); while (!s_axis_tready);
    tracker.note_request(act, pid);
  endtask

  task automatic idle_sender(int n);
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic wait_all_results();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_queue_size(logic [4:0] v);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    tracker.write_size(v);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Mostly inserts and removes of identifiers that are held, with small identifier values
  // so that duplicates are common.
  task automatic pick_request(output action_t act, output id_t pid);
    int held;
    int r;
    int w_ins;
    held = tracker.held;
    w_ins = (held >= tracker.ring_len()) ? 25 : 50;
    r = $urandom_range(0, 99);
    case ($urandom_range(0, 3))
      0, 1: pid = id_t'($urandom_range(0, 7));
      2: pid = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default: pid = id_t'($urandom_range(0, 255));
    endcase
    if (r < 4) begin
      act = ACT_NOP;
    end else if (r < 4 + w_ins) begin
      act = ACT_INSERT;
    end else if (r < 29 + w_ins) begin
      act = ACT_POP;
    end else begin
      act = ACT_REMOVE;
      if (held > 0 && $urandom_range(0, 9) < 7) pid = tracker.entry_at($urandom_range(0, held - 1));
    end
  endtask

  initial begin : stimulus
    logic [4:0] sizes[9];
    int         burst_left;
    action_t    act;
    id_t        pid;
    sizes = '{5'd16, 5'd1, 5'd2, 5'd0, 5'd31, 5'd5, 5'd16, 5'd3, 5'd16};
    sizes[8] = 5'($urandom_range(1, 16));
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = ACT_NOP;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Empty queue failures, then order-keeping removal at the head, middle and tail.
    push_request(ACT_POP, 8'h00);
    push_request(ACT_REMOVE, 8'h42);
    push_request(ACT_NOP, 8'hFF);
    push_request(ACT_INSERT, 8'h00);
    push_request(ACT_INSERT, 8'hFF);
    push_request(ACT_INSERT, 8'h5A);
    push_request(ACT_INSERT, 8'hFF);
    push_request(ACT_INSERT, 8'hA5);
    push_request(ACT_REMOVE, 8'hFF);
    push_request(ACT_REMOVE, 8'h00);
    push_request(ACT_REMOVE, 8'hA5);
    push_request(ACT_REMOVE, 8'h77);
    push_request(ACT_POP, 8'hFF);
    push_request(ACT_POP, 8'h00);
    push_request(ACT_POP, 8'h00);
    wait_all_results();

    // A single slot ring fills with one entry.
    write_queue_size(5'd1);
    push_request(ACT_INSERT, 8'h11);
    push_request(ACT_INSERT, 8'h22);
    push_request(ACT_REMOVE, 8'h22);
    push_request(ACT_REMOVE, 8'h11);
    push_request(ACT_INSERT, 8'h33);
    push_request(ACT_POP, 8'h00);
    push_request(ACT_POP, 8'h00);

    for (int p = 0; p < 9; p++) begin
      wait_all_results();
      write_queue_size(sizes[p]);
      burst_left = 0;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ((p == 2 && i == 40) || (p == 6 && i == 60)) hold_asks++;
        if (p == 4 && i == 90) wait_all_results();
        if (burst_left == 0) begin
          int gap;
          gap = $urandom_range(0, 12);
          if (gap > 0) idle_sender(gap);
          burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        pick_request(act, pid);
        push_request(act, pid);
      end
    end

    wait_all_results();
    repeat (40) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending_results.size() == 0) begin
      $display("tb_ring_queue_with_removal_core OK");
    end else begin
      $display("tb_ring_queue_with_removal_core NOT OK");
    end
    $finish;
  end

endmodule
